### rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared widths, limits, command, direction, mode and configuration codes
// and the sequencer state type for the rotator position stepper.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int AZ_W     = 9;
    localparam int EL_W     = 8;
    localparam int SPEED_W  = 10;
    localparam int PERIOD_W = 8;
    localparam int KIND_W   = 2;
    localparam int DIR_W    = 2;
    localparam int MODE_W   = 2;
    localparam int CFG_A_W  = 1;

    localparam logic [AZ_W-1:0]     AZ_MAX     = AZ_W'(450);
    localparam logic [EL_W-1:0]     EL_MAX     = EL_W'(180);
    localparam logic [SPEED_W-1:0]  SPEED_MIN  = SPEED_W'(1);
    localparam logic [SPEED_W-1:0]  SPEED_MAX  = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0]  PERIOD_NUM = SPEED_W'(1000);
    localparam logic [PERIOD_W-1:0] PERIOD_CAP = PERIOD_W'(200);

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MANUAL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd3;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_READY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

    localparam logic [CFG_A_W-1:0] CFG_SPEED_AZ = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_SPEED_EL = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } state_t;

endpackage

### rtl/rps_cfg_if.sv
// ----------------------------------------------------------------------------
// rps_cfg_if
// Configuration write channel: register address and write data.
// ----------------------------------------------------------------------------
interface rps_cfg_if import rps_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CFG_A_W-1:0] addr;
    logic [SPEED_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);

endinterface

### rtl/rps_cmd_if.sv
// ----------------------------------------------------------------------------
// rps_cmd_if
// Command channel: tick, move-to, manual and stop items.
// ----------------------------------------------------------------------------
interface rps_cmd_if import rps_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [AZ_W-1:0]   goal_az;
    logic [EL_W-1:0]   goal_el;
    logic [DIR_W-1:0]  direction;

    modport source (output valid, output kind, output goal_az, output goal_el,
                    output direction, input ready);
    modport sink   (input valid, input kind, input goal_az, input goal_el,
                    input direction, output ready);

endinterface

### rtl/rps_res_if.sv
// ----------------------------------------------------------------------------
// rps_res_if
// Result channel: positions, mode, arrival and step period.
// ----------------------------------------------------------------------------
interface rps_res_if import rps_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [AZ_W-1:0]     az_now;
    logic [EL_W-1:0]     el_now;
    logic [MODE_W-1:0]   mode;
    logic                arrived;
    logic [PERIOD_W-1:0] step_period_ms;
    logic                period_valid;

    modport source (output valid, output az_now, output el_now, output mode,
                    output arrived, output step_period_ms, output period_valid,
                    input ready);
    modport sink   (input valid, input az_now, input el_now, input mode,
                    input arrived, input step_period_ms, input period_valid,
                    output ready);

endinterface

### rtl/rps_divider.sv
// ----------------------------------------------------------------------------
// rps_divider
// Restoring radix-2 divider, one quotient bit per cycle, dividing the fixed
// period numerator by the speed.
// ----------------------------------------------------------------------------
module rps_divider import rps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SPEED_W-1:0] divisor,
    output logic               done,
    output logic [SPEED_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SPEED_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPEED_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SPEED_W-1:0] rem_reg;
    logic [SPEED_W-1:0] rem_next;
    logic [SPEED_W-1:0] quo_reg;
    logic [SPEED_W-1:0] quo_next;
    logic [SPEED_W-1:0] dvs_reg;
    logic [SPEED_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SPEED_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = SPEED_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[SPEED_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[SPEED_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= PERIOD_NUM;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/rotator_position_stepper.sv
// ----------------------------------------------------------------------------
// rotator_position_stepper
// Two-axis rotator position stepper: move-to, manual, stop and tick commands
// with step period derived from the axis speeds.
// ----------------------------------------------------------------------------
// result: registered after the ST_DIV and ST_WB states of the sequencer
// one command at a time, taken in ST_IDLE, through the 10-step shared divider
// every command, tick included, passes through the divider sequence
// the next command is taken while a finished result waits in the output register
// reset: positions, goals and mode clear to zero, both speeds reset to 1
// ----------------------------------------------------------------------------
module rotator_position_stepper import rps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rps_cfg_if.sink    cfg,
    rps_cmd_if.sink    cmd,
    rps_res_if.source  res
);

    state_t state_reg;
    state_t state_next;

    logic               cmd_ready;
    logic               div_start;
    logic               wb_fire;
    logic               div_done;
    logic [SPEED_W-1:0] div_quo;

    logic [SPEED_W-1:0] speed_az_reg;
    logic [SPEED_W-1:0] speed_el_reg;
    logic [SPEED_W-1:0] sa_c;
    logic [SPEED_W-1:0] se_c;
    logic [SPEED_W-1:0] speed_max;

    logic [KIND_W-1:0]  kind_reg;
    logic [AZ_W-1:0]    gaz_reg;
    logic [EL_W-1:0]    gel_reg;
    logic [DIR_W-1:0]   dir_reg;

    logic [AZ_W-1:0]    az_pos_reg;
    logic [AZ_W-1:0]    az_pos_next;
    logic [EL_W-1:0]    el_pos_reg;
    logic [EL_W-1:0]    el_pos_next;
    logic [AZ_W-1:0]    az_goal_reg;
    logic [AZ_W-1:0]    az_goal_next;
    logic [EL_W-1:0]    el_goal_reg;
    logic [EL_W-1:0]    el_goal_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;

    logic [AZ_W-1:0]    az_step;
    logic [EL_W-1:0]    el_step;
    logic [PERIOD_W-1:0] period;
    logic                arrived_next;
    logic [PERIOD_W-1:0] period_next;
    logic                pvalid_next;

    logic                res_valid_reg;
    logic [AZ_W-1:0]     res_az_reg;
    logic [EL_W-1:0]     res_el_reg;
    logic [MODE_W-1:0]   res_mode_reg;
    logic                res_arrived_reg;
    logic [PERIOD_W-1:0] res_period_reg;
    logic                res_pvalid_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_az_reg <= SPEED_MIN;
            speed_el_reg <= SPEED_MIN;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_SPEED_AZ: speed_az_reg <= cfg.data;
                CFG_SPEED_EL: speed_el_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // divisor is the larger clamped speed
    always_comb
    begin
        sa_c = speed_az_reg;
        se_c = speed_el_reg;
        if (speed_az_reg == '0)
        begin
            sa_c = SPEED_MIN;
        end
        else if (speed_az_reg > SPEED_MAX)
        begin
            sa_c = SPEED_MAX;
        end
        if (speed_el_reg == '0)
        begin
            se_c = SPEED_MIN;
        end
        else if (speed_el_reg > SPEED_MAX)
        begin
            se_c = SPEED_MAX;
        end
        speed_max = (sa_c > se_c) ? sa_c : se_c;
    end

    rps_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (speed_max),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign period = (div_quo > SPEED_W'(PERIOD_CAP)) ? PERIOD_CAP
                                                     : div_quo[PERIOD_W-1:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        div_start = 1'b0;
        wb_fire   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                div_start = cmd.valid;
            end
            ST_WB:
            begin
                wb_fire = !res_valid_reg || res.ready;
            end
            default: ;
        endcase
    end

    assign cmd.ready = cmd_ready;

    // command capture, goals clamped on the way in
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd_ready)
        begin
            kind_reg <= cmd.kind;
            gaz_reg  <= (cmd.goal_az > AZ_MAX) ? AZ_MAX : cmd.goal_az;
            gel_reg  <= (cmd.goal_el > EL_MAX) ? EL_MAX : cmd.goal_el;
            dir_reg  <= cmd.direction;
        end
    end

    // one step toward goal per axis
    always_comb
    begin
        az_step = az_pos_reg;
        el_step = el_pos_reg;
        if (az_goal_reg > az_pos_reg)
        begin
            az_step = az_pos_reg + 1'b1;
        end
        else if (az_goal_reg < az_pos_reg)
        begin
            az_step = az_pos_reg - 1'b1;
        end
        if (el_goal_reg > el_pos_reg)
        begin
            el_step = el_pos_reg + 1'b1;
        end
        else if (el_goal_reg < el_pos_reg)
        begin
            el_step = el_pos_reg - 1'b1;
        end
    end

    always_comb
    begin
        az_pos_next  = az_pos_reg;
        el_pos_next  = el_pos_reg;
        az_goal_next = az_goal_reg;
        el_goal_next = el_goal_reg;
        mode_next    = mode_reg;
        arrived_next = 1'b0;
        period_next  = '0;
        pvalid_next  = 1'b0;
        case (kind_reg)
            KIND_TICK:
            begin
                az_pos_next  = az_step;
                el_pos_next  = el_step;
                arrived_next = (az_step == az_goal_reg) && (el_step == el_goal_reg);
            end
            KIND_MOVE:
            begin
                // already at both goals: nothing changes
                if (!((gaz_reg == az_pos_reg) && (gel_reg == el_pos_reg)))
                begin
                    mode_next    = MODE_MOVING;
                    az_goal_next = gaz_reg;
                    el_goal_next = gel_reg;
                    period_next  = period;
                    pvalid_next  = 1'b1;
                end
            end
            KIND_MANUAL:
            begin
                mode_next   = MODE_MANUAL;
                period_next = period;
                pvalid_next = 1'b1;
                case (dir_reg)
                    DIR_RIGHT:
                    begin
                        az_goal_next = AZ_MAX;
                        el_goal_next = el_pos_reg;
                    end
                    DIR_LEFT:
                    begin
                        az_goal_next = '0;
                        el_goal_next = el_pos_reg;
                    end
                    DIR_UP:
                    begin
                        az_goal_next = az_pos_reg;
                        el_goal_next = EL_MAX;
                    end
                    default:
                    begin
                        az_goal_next = az_pos_reg;
                        el_goal_next = '0;
                    end
                endcase
            end
            default:
            begin
                az_goal_next = az_pos_reg;
                el_goal_next = el_pos_reg;
                mode_next    = MODE_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_pos_reg  <= '0;
            el_pos_reg  <= '0;
            az_goal_reg <= '0;
            el_goal_reg <= '0;
            mode_reg    <= MODE_READY;
        end
        else if (wb_fire)
        begin
            az_pos_reg  <= az_pos_next;
            el_pos_reg  <= el_pos_next;
            az_goal_reg <= az_goal_next;
            el_goal_reg <= el_goal_next;
            mode_reg    <= mode_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (wb_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            res_az_reg      <= az_pos_next;
            res_el_reg      <= el_pos_next;
            res_mode_reg    <= mode_next;
            res_arrived_reg <= arrived_next;
            res_period_reg  <= period_next;
            res_pvalid_reg  <= pvalid_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.az_now         = res_az_reg;
    assign res.el_now         = res_el_reg;
    assign res.mode           = res_mode_reg;
    assign res.arrived        = res_arrived_reg;
    assign res.step_period_ms = res_period_reg;
    assign res.period_valid   = res_pvalid_reg;

`ifndef SYNTHESIS
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd_ready) |=> (state_reg == ST_DIV))
        else $error("command transfer did not start the divide sequence");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (az_pos_reg <= AZ_MAX) && (el_pos_reg <= EL_MAX))
        else $error("axis position beyond its limit");

    a_wb_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        wb_fire |-> (!res_valid_reg || res.ready))
        else $error("write-back would overwrite a pending result");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_pvalid_reg) |->
            ((res_period_reg != '0) && (res_period_reg <= PERIOD_CAP)))
        else $error("step period outside 1..200");
`endif

endmodule

### tb/tb_rotator_position_stepper.sv
// ----------------------------------------------------------------------------
// tb_rotator_position_stepper
// Self-checking bench for the two-axis rotator position stepper. A short
// directed run covers the axis limits, goal clamping, an ignored move-to, a
// move-to that matches only one axis, and every manual direction. A long
// drive then takes both axes to their upper limits. Random command sequences
// follow under several speed settings, the extremes among them. Every
// command is predicted in the bench, and each result is compared field by
// field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rotator_position_stepper;

    import rps_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 90;
    localparam int NUM_PHASES   = 8;
    localparam int HAUL_TICKS   = 452;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [AZ_W-1:0]   goal_az;
        logic [EL_W-1:0]   goal_el;
        logic [DIR_W-1:0]  direction;
    } rotator_cmd_t;

    typedef struct packed {
        logic [AZ_W-1:0]     az_now;
        logic [EL_W-1:0]     el_now;
        logic [MODE_W-1:0]   mode;
        logic                arrived;
        logic [PERIOD_W-1:0] step_period_ms;
        logic                period_valid;
    } rotator_report_t;

    class rotator_scoreboard;
        logic [SPEED_W-1:0] speed_az;
        logic [SPEED_W-1:0] speed_el;
        logic [AZ_W-1:0]    az_pos;
        logic [AZ_W-1:0]    az_goal;
        logic [EL_W-1:0]    el_pos;
        logic [EL_W-1:0]    el_goal;
        logic [MODE_W-1:0]  drive_mode;
        rotator_report_t    pending_reports[$];
        int                 errors;
        int                 results_seen;

        function new();
            speed_az     = SPEED_MIN;
            speed_el     = SPEED_MIN;
            az_pos       = '0;
            az_goal      = '0;
            el_pos       = '0;
            el_goal      = '0;
            drive_mode   = MODE_READY;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] addr, logic [SPEED_W-1:0] data);
            if (addr == CFG_SPEED_AZ)
            begin
                speed_az = data;
            end
            else if (addr == CFG_SPEED_EL)
            begin
                speed_el = data;
            end
        endfunction

        function int unsigned axis_divisor(logic [SPEED_W-1:0] speed);
            if (speed < SPEED_MIN)
            begin
                return 32'(SPEED_MIN);
            end
            if (speed > SPEED_MAX)
            begin
                return 32'(SPEED_MAX);
            end
            return 32'(speed);
        endfunction

        function logic [PERIOD_W-1:0] step_period();
            int unsigned p;
            int unsigned pa;
            int unsigned pe;
            p  = 32'(PERIOD_CAP);
            pa = 32'(PERIOD_NUM) / axis_divisor(speed_az);
            pe = 32'(PERIOD_NUM) / axis_divisor(speed_el);
            if (pa < p)
            begin
                p = pa;
            end
            if (pe < p)
            begin
                p = pe;
            end
            return PERIOD_W'(p);
        endfunction

        function logic [AZ_W-1:0] toward(logic [AZ_W-1:0] pos, logic [AZ_W-1:0] goal);
            if (goal > pos)
            begin
                return pos + 1'b1;
            end
            if (goal < pos)
            begin
                return pos - 1'b1;
            end
            return pos;
        endfunction

        // advance the rotator state by one accepted command
        function void note_command(rotator_cmd_t c);
            rotator_report_t r;
            logic [AZ_W-1:0] gaz;
            logic [EL_W-1:0] gel;
            r = '0;
            case (c.kind)
                KIND_TICK:
                begin
                    az_pos    = toward(az_pos, az_goal);
                    el_pos    = EL_W'(toward(AZ_W'(el_pos), AZ_W'(el_goal)));
                    r.arrived = (az_pos == az_goal) && (el_pos == el_goal);
                end
                KIND_MOVE:
                begin
                    gaz = (c.goal_az > AZ_MAX) ? AZ_MAX : c.goal_az;
                    gel = (c.goal_el > EL_MAX) ? EL_MAX : c.goal_el;
                    // ignored only when both axes are already there
                    if (!(gaz == az_pos && gel == el_pos))
                    begin
                        drive_mode       = MODE_MOVING;
                        az_goal          = gaz;
                        el_goal          = gel;
                        r.step_period_ms = step_period();
                        r.period_valid   = 1'b1;
                    end
                end
                KIND_MANUAL:
                begin
                    drive_mode = MODE_MANUAL;
                    case (c.direction)
                        DIR_RIGHT:
                        begin
                            az_goal = AZ_MAX;
                            el_goal = el_pos;
                        end
                        DIR_LEFT:
                        begin
                            az_goal = '0;
                            el_goal = el_pos;
                        end
                        DIR_UP:
                        begin
                            az_goal = az_pos;
                            el_goal = EL_MAX;
                        end
                        default:
                        begin
                            az_goal = az_pos;
                            el_goal = '0;
                        end
                    endcase
                    r.step_period_ms = step_period();
                    r.period_valid   = 1'b1;
                end
                default:
                begin
                    az_goal    = az_pos;
                    el_goal    = el_pos;
                    drive_mode = MODE_READY;
                end
            endcase
            r.az_now = az_pos;
            r.el_now = el_pos;
            r.mode   = drive_mode;
            pending_reports.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
            begin
                $display("ERROR result %0d: %s", results_seen, msg);
            end
        endtask

        task check_report(rotator_report_t got);
            rotator_report_t want;
            results_seen++;
            if (pending_reports.size() == 0)
            begin
                report($sformatf("unexpected transfer az=%0d el=%0d", got.az_now, got.el_now));
                return;
            end
            want = pending_reports.pop_front();
            if (got.az_now != want.az_now)
            begin
                report($sformatf("az_now %0d, want %0d", got.az_now, want.az_now));
            end
            if (got.el_now != want.el_now)
            begin
                report($sformatf("el_now %0d, want %0d", got.el_now, want.el_now));
            end
            if (got.mode != want.mode)
            begin
                report($sformatf("mode %0d, want %0d", got.mode, want.mode));
            end
            if (got.arrived != want.arrived)
            begin
                report($sformatf("arrived %0b, want %0b", got.arrived, want.arrived));
            end
            if (got.step_period_ms != want.step_period_ms)
            begin
                report($sformatf("step_period_ms %0d, want %0d",
                                 got.step_period_ms, want.step_period_ms));
            end
            if (got.period_valid != want.period_valid)
            begin
                report($sformatf("period_valid %0b, want %0b",
                                 got.period_valid, want.period_valid));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   tx_steady;
    bit   rx_steady;
    int   items_sent;

    rotator_scoreboard sb = new();

    rps_cfg_if cfg_bus ();
    rps_cmd_if cmd_bus ();
    rps_res_if res_bus ();

    rotator_position_stepper DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_cmd(logic [KIND_W-1:0] kind, logic [AZ_W-1:0] gaz,
                            logic [EL_W-1:0] gel, logic [DIR_W-1:0] dir);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.kind      <= kind;
        cmd_bus.goal_az   <= gaz;
        cmd_bus.goal_el   <= gel;
        cmd_bus.direction <= dir;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        items_sent++;
    endtask

    // unused fields carry random values
    task automatic send_tick();
        send_cmd(KIND_TICK, AZ_W'($urandom), EL_W'($urandom), DIR_W'($urandom));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_tick();
    endtask

    task automatic send_move(logic [AZ_W-1:0] gaz, logic [EL_W-1:0] gel);
        send_cmd(KIND_MOVE, gaz, gel, DIR_W'($urandom));
    endtask

    task automatic send_manual(logic [DIR_W-1:0] dir);
        send_cmd(KIND_MANUAL, AZ_W'($urandom), EL_W'($urandom), dir);
    endtask

    task automatic send_stop();
        send_cmd(KIND_STOP, AZ_W'($urandom), EL_W'($urandom), DIR_W'($urandom));
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0) @(posedge clk);
    endtask

    task automatic write_speeds(logic [SPEED_W-1:0] az_speed, logic [SPEED_W-1:0] el_speed);
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= CFG_SPEED_AZ;
        cfg_bus.data  <= az_speed;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.addr  <= CFG_SPEED_EL;
        cfg_bus.data  <= el_speed;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // transfer monitor: commands are noted before results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                sb.write_reg(cfg_bus.addr, cfg_bus.data);
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                sb.note_command(rotator_cmd_t'({cmd_bus.kind, cmd_bus.goal_az,
                                                cmd_bus.goal_el, cmd_bus.direction}));
            end
            if (res_bus.valid && res_bus.ready)
            begin
                sb.check_report(rotator_report_t'({res_bus.az_now, res_bus.el_now,
                                                   res_bus.mode, res_bus.arrived,
                                                   res_bus.step_period_ms,
                                                   res_bus.period_valid}));
            end
        end
    end

    initial
    begin : result_sink
        int  gap;
        bit  hold_for_result;
        res_bus.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = pick_gap(rx_steady);
            if (gap > 0)
            begin
                // sometimes stall while a finished result is waiting
                hold_for_result = 1'($urandom_range(0, 1));
                res_bus.ready <= 1'b0;
                @(posedge clk);
                if (hold_for_result)
                begin
                    while (!res_bus.valid) @(posedge clk);
                end
                repeat (gap - 1) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int              pick;
        int              n;
        int              a;
        int              e;
        int              phase_start;
        logic [AZ_W-1:0] gaz;
        logic [EL_W-1:0] gel;

        rst_n             = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.addr      = CFG_SPEED_AZ;
        cfg_bus.data      = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.kind      = KIND_TICK;
        cmd_bus.goal_az   = '0;
        cmd_bus.goal_el   = '0;
        cmd_bus.direction = DIR_RIGHT;
        items_sent        = 0;
        tx_steady         = 1'($urandom_range(0, 1));
        rx_steady         = 1'($urandom_range(0, 1));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // zero speed counts as one, out-of-range speed counts as the maximum
        write_speeds('0, '1);

        // lower limits, ignored move-to and clamping
        send_tick();
        send_move('0, '0);
        send_manual(DIR_LEFT);
        send_tick();
        send_manual(DIR_DOWN);
        send_tick();
        send_move('1, '1);
        send_ticks(2);
        send_stop();
        send_tick();
        // only the azimuth differs
        send_move(AZ_W'(1), EL_W'(2));
        send_ticks(3);
        send_manual(DIR_RIGHT);
        send_tick();
        send_manual(DIR_UP);
        send_tick();
        send_move('0, '0);
        send_tick();
        send_move(AZ_MAX + 1'b1, EL_MAX + 1'b1);
        send_tick();
        send_stop();
        wait_drained();
        send_move(sb.az_pos, sb.el_pos);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       write_speeds(SPEED_MIN, SPEED_MIN);
                1:       write_speeds(SPEED_MAX, SPEED_MAX);
                2:       write_speeds(SPEED_W'(5), SPEED_W'(4));
                3:       write_speeds(SPEED_W'(7), SPEED_W'(300));
                4:       write_speeds(SPEED_W'(999), SPEED_W'(6));
                5:       write_speeds('1, '0);
                default: write_speeds(SPEED_W'($urandom), SPEED_W'($urandom));
            endcase
            tx_steady   = ($urandom_range(0, 3) == 0);
            rx_steady   = ($urandom_range(0, 3) == 0);
            phase_start = items_sent;

            if (phase == 0)
            begin
                // long drive up to both upper limits
                send_move(AZ_W'($urandom_range(450, 511)), EL_W'($urandom_range(180, 255)));
                send_ticks(HAUL_TICKS);
                send_manual(DIR_RIGHT);
                send_ticks(3);
                send_manual(DIR_UP);
                send_ticks(3);
                phase_start = items_sent;
            end

            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    // short move near the current position, then ticks
                    a = int'($urandom_range(0, 24)) - 12 + int'(sb.az_pos);
                    e = int'($urandom_range(0, 24)) - 12 + int'(sb.el_pos);
                    a = (a < 0) ? 0 : (a > 511) ? 511 : a;
                    e = (e < 0) ? 0 : (e > 255) ? 255 : e;
                    send_move(AZ_W'(a), EL_W'(e));
                    send_ticks($urandom_range(0, 18));
                end
                else if (pick < 62)
                begin
                    send_manual(DIR_W'($urandom));
                    send_ticks($urandom_range(0, 10));
                    if ($urandom_range(0, 1))
                    begin
                        send_stop();
                    end
                end
                else if (pick < 70)
                begin
                    send_stop();
                    send_ticks($urandom_range(0, 2));
                end
                else if (pick < 80)
                begin
                    send_cmd(KIND_W'($urandom), AZ_W'($urandom), EL_W'($urandom),
                             DIR_W'($urandom));
                end
                else if (pick < 88)
                begin
                    send_move(AZ_W'($urandom), EL_W'($urandom));
                    send_ticks($urandom_range(0, 6));
                end
                else if (pick < 93)
                begin
                    // move-to the spot already held, clamped goals included
                    wait_drained();
                    gaz = sb.az_pos;
                    gel = sb.el_pos;
                    if (gaz == AZ_MAX && $urandom_range(0, 1))
                    begin
                        gaz = AZ_W'($urandom_range(450, 511));
                    end
                    if (gel == EL_MAX && $urandom_range(0, 1))
                    begin
                        gel = EL_W'($urandom_range(180, 255));
                    end
                    send_move(gaz, gel);
                    send_tick();
                end
                else
                begin
                    send_manual(DIR_W'($urandom));
                    send_stop();
                    n = $urandom_range(1, 3);
                    send_ticks(n);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
